@@ hw/rtl/assert_macros.svh @@
// Assertion macros of the cycle length block, used by graph_cycle_length_dfs_top.
// Depends on nothing; users supply clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every clock edge, held off while in reset.
`define GCL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property at every clock edge, reset included.
`define GCL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ hw/rtl/gcl_pkg.sv @@
// Package of the cycle length block: defaults, field widths, ALU codes, result struct.
// Used by every module of the block but gcl_ram.
`timescale 1ns / 1ps
package gcl_pkg;

  localparam int unsigned MAX_VERTICES_DEF = 256;
  localparam int unsigned MAX_EDGES_DEF    = 512;
  localparam int unsigned END_W            = 8;
  localparam int unsigned CNT_W            = 9;
  localparam logic [CNT_W-1:0] VCOUNT_RST  = 9'd256;

  typedef enum logic [1:0] {
    ALU_INC  = 2'd0,
    ALU_DEC  = 2'd1,
    ALU_DIST = 2'd2
  } alu_op_e;

  typedef struct packed {
    logic             valid;
    logic [CNT_W-1:0] length;
    logic             dropped;
  } res_t;

endpackage

@@ hw/rtl/graph_cycle_length_dfs_top.sv @@
// Channel   | Direction | Handshake              | Payload
// edge in   | input     | in_valid_i/in_ready_o  | end_a_i, end_b_i, last_edge_i
// result    | output    | out_valid_o/out_ready_i| cycle_length_o, edges_dropped_o
// config    | input     | cfg_we_i               | cfg_wdata_i (vertex_count)
// Stored edge: accept, then two list appends, each by ST_TAIL and ST_LINK.
// Dropped edge: flagged in ST_IDLE. Last edge: store, then walk; a list entry
// scanned passes CUR, X and CHK, a vertex entered HEAD, ENTER, TOP, K and KRD,
// a vertex left CUR, TOP, K and KRD; one RAM read per step; DONE gives the result.
// Reset clears the lists, the drop flag and the walk state; no clearing pass.
// A result waits in the output register; a new one waits until it is taken.
`timescale 1ns / 1ps
module graph_cycle_length_dfs_top #(
  parameter int unsigned MAX_VERTICES = gcl_pkg::MAX_VERTICES_DEF,
  parameter int unsigned MAX_EDGES    = gcl_pkg::MAX_EDGES_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [gcl_pkg::CNT_W-1:0] cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [gcl_pkg::END_W-1:0] end_a_i,
  input  logic [gcl_pkg::END_W-1:0] end_b_i,
  input  logic                      last_edge_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [gcl_pkg::CNT_W-1:0] cycle_length_o,
  output logic                      edges_dropped_o
);
  import gcl_pkg::*;
  `include "assert_macros.svh"

  logic [CNT_W-1:0] vcount_q;
  logic out_valid_q;
  logic [CNT_W-1:0] len_q;
  logic drop_q;
  res_t res;
  logic out_busy;

  assign out_busy = out_valid_q && !out_ready_i;

  gcl_core #(.MAX_VERTICES(MAX_VERTICES), .MAX_EDGES(MAX_EDGES)) u_core (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .end_a_i, .end_b_i, .last_edge_i,
    .vertex_count_i(vcount_q), .out_busy_i(out_busy), .res_o(res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= VCOUNT_RST;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        vcount_q <= cfg_wdata_i;
      end
      if (res.valid) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      len_q <= res.length;
      drop_q <= res.dropped;
    end
  end

  assign out_valid_o = out_valid_q;
  assign cycle_length_o = len_q;
  assign edges_dropped_o = drop_q;

  `GCL_ASSERT(a_no_overwrite, res.valid |-> (!out_valid_q || out_ready_i), "result overwritten")
  `GCL_ASSERT(a_res_shown, res.valid |=> out_valid_o, "result not presented")
  `GCL_ASSERT(a_busy_on_res, res.valid |-> !in_ready_o, "ready while finishing")

endmodule

@@ hw/rtl/gcl_ram.sv @@
// Simple dual port RAM: one write, one registered read per cycle.
// Depends on nothing.
`timescale 1ns / 1ps
module gcl_ram #(
  parameter int unsigned W = 8,
  parameter int unsigned D = 256
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [$clog2(D)-1:0] waddr_i,
  input  logic [W-1:0]         wdata_i,
  input  logic [$clog2(D)-1:0] raddr_i,
  output logic [W-1:0]         rdata_o
);

  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/gcl_alu.sv @@
// Shared arithmetic unit: increment, decrement and distance plus one.
// Depends on gcl_pkg.
`timescale 1ns / 1ps
module gcl_alu #(
  parameter int unsigned AW = 9
) (
  input  gcl_pkg::alu_op_e op_i,
  input  logic [AW-1:0]    a_i,
  input  logic [AW-1:0]    b_i,
  output logic [AW-1:0]    y_o
);
  import gcl_pkg::*;

  always_comb begin
    case (op_i)
      ALU_INC:  y_o = a_i + 1'b1;
      ALU_DEC:  y_o = a_i - 1'b1;
      ALU_DIST: y_o = ((a_i >= b_i) ? (a_i - b_i) : (b_i - a_i)) + 1'b1;
      default:  y_o = a_i;
    endcase
  end

endmodule

@@ hw/rtl/gcl_core.sv @@
// Sequencer of the cycle length block: edge store and depth-first walk.
// Depends on gcl_pkg, gcl_ram and gcl_alu.
`timescale 1ns / 1ps
module gcl_core #(
  parameter int unsigned MAX_VERTICES = gcl_pkg::MAX_VERTICES_DEF,
  parameter int unsigned MAX_EDGES    = gcl_pkg::MAX_EDGES_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [gcl_pkg::END_W-1:0] end_a_i,
  input  logic [gcl_pkg::END_W-1:0] end_b_i,
  input  logic                      last_edge_i,
  input  logic [gcl_pkg::CNT_W-1:0] vertex_count_i,
  input  logic                      out_busy_i,
  output gcl_pkg::res_t             res_o
);
  import gcl_pkg::*;

  localparam int unsigned VD    = MAX_VERTICES;
  localparam int unsigned VW    = $clog2(VD);
  localparam int unsigned LD    = 2 * MAX_EDGES;
  localparam int unsigned LAW   = $clog2(LD);
  localparam int unsigned FW    = $clog2(LD + 1);
  localparam int unsigned AW    = VW + 1;
  localparam int unsigned PW    = LAW + 1;
  localparam int unsigned VCW   = $clog2(VD + 1);
  localparam int unsigned LIM_W = (VCW > CNT_W) ? VCW : CNT_W;

  typedef enum logic [11:0] {
    ST_IDLE  = 12'b000000000001,
    ST_TAIL  = 12'b000000000010,
    ST_LINK  = 12'b000000000100,
    ST_HEAD  = 12'b000000001000,
    ST_ENTER = 12'b000000010000,
    ST_TOP   = 12'b000000100000,
    ST_K     = 12'b000001000000,
    ST_KRD   = 12'b000010000000,
    ST_CUR   = 12'b000100000000,
    ST_X     = 12'b001000000000,
    ST_CHK   = 12'b010000000000,
    ST_DONE  = 12'b100000000000
  } state_e;

  state_e state_q, state_d;
  logic [VD-1:0] hv_q, hv_d, vis_q, vis_d;
  logic [FW-1:0] fill_q, fill_d;
  logic drop_q, drop_d;
  logic [AW-1:0] sl_q, sl_d;
  logic [VW-1:0] owner_q, owner_d, tgt_q, tgt_d;
  logic second_q, second_d, last_q, last_d;
  logic [VW-1:0] k_q, k_d, dk_q, dk_d, pk_q, pk_d, x_q, x_d;
  logic [PW-1:0] cur_q, cur_d, nxt_q, nxt_d;
  logic [VW-1:0] ev_q, ev_d, ed_q, ed_d, ep_q, ep_d;
  logic [AW-1:0] len_q, len_d;

  logic head_we, tail_we, tgt_we, nxt_we, dep_we, par_we, cur_we, stk_we;
  logic [VW-1:0] head_wa, head_ra, tail_wa, tail_ra, dep_wa, dep_ra, par_wa, par_ra;
  logic [VW-1:0] cur_wa, cur_ra, stk_wa, stk_ra;
  logic [LAW-1:0] tgt_wa, tgt_ra, nxt_wa, nxt_ra;
  logic [LAW-1:0] head_wd, head_rd, tail_wd, tail_rd;
  logic [VW-1:0] tgt_wd, tgt_rd, dep_wd, dep_rd, par_wd, par_rd, stk_wd, stk_rd;
  logic [PW-1:0] nxt_wd, nxt_rd, cur_wd, cur_rd;

  alu_op_e alu_op;
  logic [AW-1:0] alu_a, alu_b, alu_y;

  logic [LIM_W-1:0] lim;
  logic edge_ok, start_walk;

  gcl_alu #(.AW(AW)) u_alu (.op_i(alu_op), .a_i(alu_a), .b_i(alu_b), .y_o(alu_y));

  gcl_ram #(.W(LAW), .D(VD)) u_head (.clk_i, .we_i(head_we), .waddr_i(head_wa),
    .wdata_i(head_wd), .raddr_i(head_ra), .rdata_o(head_rd));
  gcl_ram #(.W(LAW), .D(VD)) u_tail (.clk_i, .we_i(tail_we), .waddr_i(tail_wa),
    .wdata_i(tail_wd), .raddr_i(tail_ra), .rdata_o(tail_rd));
  gcl_ram #(.W(VW), .D(LD)) u_ltgt (.clk_i, .we_i(tgt_we), .waddr_i(tgt_wa),
    .wdata_i(tgt_wd), .raddr_i(tgt_ra), .rdata_o(tgt_rd));
  gcl_ram #(.W(PW), .D(LD)) u_lnxt (.clk_i, .we_i(nxt_we), .waddr_i(nxt_wa),
    .wdata_i(nxt_wd), .raddr_i(nxt_ra), .rdata_o(nxt_rd));
  gcl_ram #(.W(VW), .D(VD)) u_dep (.clk_i, .we_i(dep_we), .waddr_i(dep_wa),
    .wdata_i(dep_wd), .raddr_i(dep_ra), .rdata_o(dep_rd));
  gcl_ram #(.W(VW), .D(VD)) u_par (.clk_i, .we_i(par_we), .waddr_i(par_wa),
    .wdata_i(par_wd), .raddr_i(par_ra), .rdata_o(par_rd));
  gcl_ram #(.W(PW), .D(VD)) u_cur (.clk_i, .we_i(cur_we), .waddr_i(cur_wa),
    .wdata_i(cur_wd), .raddr_i(cur_ra), .rdata_o(cur_rd));
  gcl_ram #(.W(VW), .D(VD)) u_stk (.clk_i, .we_i(stk_we), .waddr_i(stk_wa),
    .wdata_i(stk_wd), .raddr_i(stk_ra), .rdata_o(stk_rd));

  assign lim = (LIM_W'(vertex_count_i) < LIM_W'(VD)) ? LIM_W'(vertex_count_i) : LIM_W'(VD);
  assign edge_ok = (LIM_W'(end_a_i) < lim) && (LIM_W'(end_b_i) < lim) &&
                   ((FW + 1)'(fill_q) + (FW + 1)'(2) <= (FW + 1)'(LD));
  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q; hv_d = hv_q; vis_d = vis_q; fill_d = fill_q; drop_d = drop_q;
    sl_d = sl_q; owner_d = owner_q; tgt_d = tgt_q; second_d = second_q; last_d = last_q;
    k_d = k_q; dk_d = dk_q; pk_d = pk_q; x_d = x_q; cur_d = cur_q; nxt_d = nxt_q;
    ev_d = ev_q; ed_d = ed_q; ep_d = ep_q; len_d = len_q;
    start_walk = 1'b0;
    alu_op = ALU_INC; alu_a = sl_q; alu_b = '0;
    head_we = 1'b0; head_wa = owner_q; head_wd = fill_q[LAW-1:0]; head_ra = ev_q;
    tail_we = 1'b0; tail_wa = owner_q; tail_wd = fill_q[LAW-1:0]; tail_ra = owner_q;
    tgt_we = 1'b0; tgt_wa = fill_q[LAW-1:0]; tgt_wd = tgt_q; tgt_ra = cur_q[LAW-1:0];
    nxt_we = 1'b0; nxt_wa = fill_q[LAW-1:0]; nxt_wd = '0; nxt_ra = cur_q[LAW-1:0];
    dep_we = 1'b0; dep_wa = ev_q; dep_wd = ed_q; dep_ra = stk_rd;
    par_we = 1'b0; par_wa = ev_q; par_wd = ep_q; par_ra = stk_rd;
    cur_we = 1'b0; cur_wa = ev_q; cur_wd = {hv_q[ev_q], head_rd}; cur_ra = stk_rd;
    stk_we = 1'b0; stk_wa = sl_q[VW-1:0]; stk_wd = ev_q; stk_ra = alu_y[VW-1:0];
    res_o = '{valid: 1'b0, length: CNT_W'(len_q), dropped: drop_q};

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          last_d = last_edge_i;
          if (edge_ok) begin
            owner_d = VW'(end_a_i);
            tgt_d = VW'(end_b_i);
            second_d = 1'b0;
            state_d = ST_TAIL;
          end else begin
            drop_d = 1'b1;
            start_walk = last_edge_i;
          end
        end
      end
      ST_TAIL: begin
        tgt_we = 1'b1;
        nxt_we = 1'b1;
        state_d = ST_LINK;
      end
      ST_LINK: begin
        if (hv_q[owner_q]) begin
          nxt_we = 1'b1;
          nxt_wa = tail_rd;
          nxt_wd = {1'b1, fill_q[LAW-1:0]};
        end else begin
          hv_d[owner_q] = 1'b1;
          head_we = 1'b1;
        end
        tail_we = 1'b1;
        fill_d = fill_q + 1'b1;
        if (!second_q) begin
          owner_d = tgt_q;
          tgt_d = owner_q;
          second_d = 1'b1;
          state_d = ST_TAIL;
        end else if (last_q) begin
          start_walk = 1'b1;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_HEAD: begin
        state_d = ST_ENTER;
      end
      ST_ENTER: begin
        vis_d[ev_q] = 1'b1;
        dep_we = 1'b1;
        par_we = 1'b1;
        cur_we = 1'b1;
        if (sl_q < AW'(VD)) begin
          stk_we = 1'b1;
          sl_d = alu_y;
        end
        state_d = ST_TOP;
      end
      ST_TOP: begin
        alu_op = ALU_DEC;
        if (sl_q == '0) begin
          len_d = '0;
          state_d = ST_DONE;
        end else begin
          state_d = ST_K;
        end
      end
      ST_K: begin
        k_d = stk_rd;
        state_d = ST_KRD;
      end
      ST_KRD: begin
        cur_d = cur_rd;
        dk_d = dep_rd;
        pk_d = par_rd;
        state_d = ST_CUR;
      end
      ST_CUR: begin
        alu_op = ALU_DEC;
        if (!cur_q[PW-1]) begin
          sl_d = alu_y;
          state_d = ST_TOP;
        end else begin
          state_d = ST_X;
        end
      end
      ST_X: begin
        x_d = tgt_rd;
        nxt_d = nxt_rd;
        dep_ra = tgt_rd;
        par_ra = tgt_rd;
        alu_a = AW'(dk_q);
        if (!vis_q[tgt_rd]) begin
          ev_d = tgt_rd;
          ed_d = alu_y[VW-1:0];
          ep_d = k_q;
          state_d = ST_HEAD;
        end else begin
          state_d = ST_CHK;
        end
      end
      ST_CHK: begin
        alu_op = ALU_DIST;
        alu_a = AW'(dk_q);
        alu_b = AW'(dep_rd);
        if (pk_q != x_q && par_rd != k_q) begin
          len_d = alu_y;
          state_d = ST_DONE;
        end else begin
          cur_we = 1'b1;
          cur_wa = k_q;
          cur_wd = nxt_q;
          cur_d = nxt_q;
          state_d = ST_CUR;
        end
      end
      ST_DONE: begin
        if (!out_busy_i) begin
          res_o.valid = 1'b1;
          hv_d = '0;
          fill_d = '0;
          drop_d = 1'b0;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (start_walk) begin
      vis_d = '0;
      sl_d = '0;
      ev_d = '0;
      ed_d = '0;
      ep_d = '0;
      state_d = ST_HEAD;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      hv_q <= '0;
      vis_q <= '0;
      fill_q <= '0;
      drop_q <= 1'b0;
      sl_q <= '0;
    end else begin
      state_q <= state_d;
      hv_q <= hv_d;
      vis_q <= vis_d;
      fill_q <= fill_d;
      drop_q <= drop_d;
      sl_q <= sl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    owner_q <= owner_d; tgt_q <= tgt_d; second_q <= second_d; last_q <= last_d;
    k_q <= k_d; dk_q <= dk_d; pk_q <= pk_d; x_q <= x_d; cur_q <= cur_d; nxt_q <= nxt_d;
    ev_q <= ev_d; ed_q <= ed_d; ep_q <= ep_d; len_q <= len_d;
  end

endmodule
